// File: design/tgcr_pkg.sv
// Shared constants, types and the 6x8 font table of the text glyph column renderer.
package tgcr_pkg;

    // Screen size in pixels.
    localparam int unsigned SCREEN_WIDTH  = 128;
    localparam int unsigned SCREEN_HEIGHT = 64;

    // Character cell size in pixels.
    localparam int unsigned CELL_W = 6;
    localparam int unsigned CELL_H = 8;

    // Column counter value of the sixth, final glyph column.
    localparam logic [2:0] CELL_LAST = 3'(CELL_W - 1);

    // Range of character codes that the font covers.
    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd90;

    // Operation codes carried in tuser of the input stream.
    localparam logic OP_WRITE_CHAR = 1'b0;
    localparam logic OP_SET_CURSOR = 1'b1;

    // One character handed from the cursor stage to the column emitter.
    typedef struct packed {
        logic [7:0]  col;    // wrapped cursor column of the first glyph column
        logic [5:0]  row;    // wrapped cursor row of the top pixel
        logic [47:0] glyph;  // six column bytes, first column in the lowest byte
    } tgcr_load_t;

    // Returns the six column bytes of one glyph, first column in bits 7:0.
    function automatic logic [47:0] glyph_lookup(input logic [5:0] idx);
        logic [47:0] g;
        case (idx)
            6'd0:  g = 48'h00_00_00_00_00_00;
            6'd1:  g = 48'h00_00_00_5F_00_00;
            6'd2:  g = 48'h00_00_07_00_07_00;
            6'd3:  g = 48'h00_14_7F_14_7F_14;
            6'd4:  g = 48'h00_12_2A_7F_2A_24;
            6'd5:  g = 48'h00_62_64_08_13_23;
            6'd6:  g = 48'h00_50_20_56_49_36;
            6'd7:  g = 48'h00_00_03_07_08_00;
            6'd8:  g = 48'h00_00_41_22_1C_00;
            6'd9:  g = 48'h00_00_1C_22_41_00;
            6'd10: g = 48'h00_2A_1C_7F_1C_2A;
            6'd11: g = 48'h00_08_08_3E_08_08;
            6'd12: g = 48'h00_00_30_70_80_00;
            6'd13: g = 48'h00_08_08_08_08_08;
            6'd14: g = 48'h00_00_60_60_00_00;
            6'd15: g = 48'h00_02_04_08_10_20;
            6'd16: g = 48'h00_3E_45_49_51_3E;
            6'd17: g = 48'h00_00_40_7F_42_00;
            6'd18: g = 48'h00_46_49_49_49_72;
            6'd19: g = 48'h00_33_4D_49_41_21;
            6'd20: g = 48'h00_10_7F_12_14_18;
            6'd21: g = 48'h00_39_45_45_45_27;
            6'd22: g = 48'h00_31_49_49_4A_3C;
            6'd23: g = 48'h00_07_09_11_21_41;
            6'd24: g = 48'h00_36_49_49_49_36;
            6'd25: g = 48'h00_1E_29_49_49_46;
            6'd26: g = 48'h00_00_00_14_00_00;
            6'd27: g = 48'h00_00_00_34_40_00;
            6'd28: g = 48'h00_41_22_14_08_00;
            6'd29: g = 48'h00_14_14_14_14_14;
            6'd30: g = 48'h00_08_14_22_41_00;
            6'd31: g = 48'h00_06_09_59_01_02;
            6'd32: g = 48'h00_4E_59_5D_41_3E;
            6'd33: g = 48'h00_7C_12_11_12_7C;
            6'd34: g = 48'h00_36_49_49_49_7F;
            6'd35: g = 48'h00_22_41_41_41_3E;
            6'd36: g = 48'h00_3E_41_41_41_7F;
            6'd37: g = 48'h00_41_49_49_49_7F;
            6'd38: g = 48'h00_01_09_09_09_7F;
            6'd39: g = 48'h00_73_51_41_41_3E;
            6'd40: g = 48'h00_7F_08_08_08_7F;
            6'd41: g = 48'h00_00_41_7F_41_00;
            6'd42: g = 48'h00_01_3F_41_40_20;
            6'd43: g = 48'h00_41_22_14_08_7F;
            6'd44: g = 48'h00_40_40_40_40_7F;
            6'd45: g = 48'h00_7F_02_1C_02_7F;
            6'd46: g = 48'h00_7F_10_08_04_7F;
            6'd47: g = 48'h00_3E_41_41_41_3E;
            6'd48: g = 48'h00_06_09_09_09_7F;
            6'd49: g = 48'h00_5E_21_51_41_3E;
            6'd50: g = 48'h00_46_29_19_09_7F;
            6'd51: g = 48'h00_32_49_49_49_26;
            6'd52: g = 48'h00_03_01_7F_01_03;
            6'd53: g = 48'h00_3F_40_40_40_3F;
            6'd54: g = 48'h00_1F_20_40_20_1F;
            6'd55: g = 48'h00_3F_40_38_40_3F;
            6'd56: g = 48'h00_63_14_08_14_63;
            6'd57: g = 48'h00_03_04_78_04_03;
            6'd58: g = 48'h00_43_4D_49_59_61;
            default: g = 48'h00_00_00_00_00_00;
        endcase
        return g;
    endfunction

endpackage

// File: design/tgcr_cursor.sv
// Input register, text cursor and wrap logic of the text glyph column renderer.
module tgcr_cursor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // char_code[7:0], cursor_col[14:8], cursor_row[20:15]
    input  logic               s_tuser,   // operation
    output logic               load_valid,
    input  logic               load_ready,
    output tgcr_pkg::tgcr_load_t load
);
    import tgcr_pkg::*;

    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] code_reg;
    logic [6:0] ccol_reg;
    logic [5:0] crow_reg;
    logic [7:0] text_col_reg;
    logic [7:0] text_col_next;
    logic [5:0] text_row_reg;
    logic [5:0] text_row_next;

    logic       printable;
    logic       is_char;
    logic       in_consume;
    logic [8:0] col_sum;
    logic       col_wrap;
    logic [7:0] row_a;
    logic [8:0] row_sum;
    logic       row_wrap;
    logic [7:0] col_fin;
    logic [5:0] row_fin;

    assign printable  = (code_reg >= FIRST_CODE) && (code_reg <= LAST_CODE);
    assign is_char    = in_valid_reg && (op_reg == OP_WRITE_CHAR) && printable;
    assign in_consume = in_valid_reg && (!is_char || load_ready);
    assign s_tready   = !in_valid_reg || in_consume;

    // Wrap to the next line when the cell would cross the right edge, then
    // to the top when it would cross the bottom edge.
    always_comb
    begin
        col_sum  = {1'b0, text_col_reg} + 9'(CELL_W);
        col_wrap = col_sum > 9'(SCREEN_WIDTH);
        row_a    = col_wrap ? ({2'b00, text_row_reg} + 8'(CELL_H)) : {2'b00, text_row_reg};
        row_sum  = {1'b0, row_a} + 9'(CELL_H);
        row_wrap = row_sum > 9'(SCREEN_HEIGHT);
        col_fin  = col_wrap ? 8'd0 : text_col_reg;
        row_fin  = row_wrap ? 6'd0 : row_a[5:0];
    end

    always_comb
    begin
        text_col_next = text_col_reg;
        text_row_next = text_row_reg;
        if (in_consume)
        begin
            if (op_reg == OP_SET_CURSOR)
            begin
                text_col_next = {1'b0, ccol_reg};
                text_row_next = crow_reg;
            end
            else if (printable)
            begin
                text_col_next = col_fin + 8'(CELL_W);
                text_row_next = row_fin;
            end
        end
    end

    assign load_valid = is_char;
    assign load.col   = col_fin;
    assign load.row   = row_fin;
    assign load.glyph = glyph_lookup(6'(code_reg - FIRST_CODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            text_col_reg <= 8'd0;
            text_row_reg <= 6'd0;
        end
        else
        begin
            text_col_reg <= text_col_next;
            text_row_reg <= text_row_next;
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            code_reg <= s_tdata[7:0];
            ccol_reg <= s_tdata[14:8];
            crow_reg <= s_tdata[20:15];
        end
    end

    // A word that makes no glyph never waits in the input register.
    a_nonchar_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !is_char) |-> in_consume)
        else $error("non-character word stalled in input register");

    // The cursor only moves when a word leaves the input register.
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_consume |=> ($stable(text_col_reg) && $stable(text_row_reg)))
        else $error("cursor changed without a consumed word");

endmodule

// File: design/tgcr_emitter.sv
// Glyph column counter and output register of the text glyph column renderer.
module tgcr_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    output logic               load_ready,
    input  tgcr_pkg::tgcr_load_t load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // column[6:0], top_row[12:7], glyph_bits[20:13]
    output logic               m_tlast    // last_column
);
    import tgcr_pkg::*;

    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic [7:0]  col_reg;
    logic [5:0]  row_reg;
    logic [47:0] glyph_reg;

    logic        m_valid_reg;
    logic [6:0]  out_col_reg;
    logic [5:0]  out_row_reg;
    logic [7:0]  out_bits_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        emit;
    logic        last;

    assign out_free   = !m_valid_reg || m_tready;
    assign emit       = busy_reg && out_free;
    assign last       = cnt_reg == CELL_LAST;
    assign load_ready = !busy_reg || (emit && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cnt_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_valid && load_ready)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (emit)
            begin
                busy_reg <= !last;
                cnt_reg  <= cnt_reg + 3'd1;
            end
            if (out_free)
            begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            col_reg   <= load.col;
            row_reg   <= load.row;
            glyph_reg <= load.glyph;
        end
        else if (emit)
        begin
            glyph_reg <= {8'd0, glyph_reg[47:8]};
        end
        if (emit)
        begin
            out_col_reg  <= 7'(col_reg + {5'd0, cnt_reg});
            out_row_reg  <= row_reg;
            out_bits_reg <= glyph_reg[7:0];
            out_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_bits_reg, out_row_reg, out_col_reg};
    assign m_tlast  = out_last_reg;

    // The column counter never runs past the sixth column.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CELL_LAST))
        else $error("column counter out of range");

    // A new character only replaces one whose last column is leaving now.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && load_ready && busy_reg) |-> (out_free && last))
        else $error("character loaded over an unfinished one");

endmodule

// File: design/text_glyph_column_renderer.sv
// Top level of the text glyph column renderer: cursor stage feeding the column emitter.
//
// Each input word either sets the text cursor (tuser high: cursor_col and cursor_row are
// stored as given) or writes one character (tuser low). A character with a code from 32
// to 90 first wraps the cursor to the next 8-pixel line when its 6-pixel cell would cross
// the right edge, and to row 0 when the cell would cross the bottom edge; it then leaves
// as six output words, one per glyph column, with bit 0 of glyph_bits as the top pixel
// and tlast on the sixth, and the cursor advances by 6 columns. Any other code produces
// no output and leaves the cursor alone. A rendered character holds the column emitter while
// its six columns leave, and the next one is taken as its last column leaves; set-cursor
// and unknown-code words pass through the input register without waiting for the emitter
// and can slip in while a character is still being emitted. The first column of a character
// passes from the input register through the emitter's glyph register to its output
// register. Screen size is fixed at 128 by 64 pixels by package constants.
module text_glyph_column_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cursor_col[14:8], cursor_row[20:15]
    input  logic        s_tuser,   // operation: 0 writes a character, 1 sets the cursor
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // column[6:0], top_row[12:7], glyph_bits[20:13]
    output logic        m_tlast    // last_column
);
    import tgcr_pkg::*;

    logic       load_valid;
    logic       load_ready;
    tgcr_load_t load;

    tgcr_cursor u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .load       (load)
    );

    tgcr_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .load       (load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
